// ===== design/sau_pkg.sv =====
`default_nettype none

package sau_pkg;

	// fixed-point formats
	localparam int IN_FRAC   = 16;
	localparam int OUT_FRAC  = 16;
	localparam int WORK_FRAC = 30;
	localparam int K_LIMIT   = OUT_FRAC + 2;

	// round(2^32 / ln2) and round(ln2 * 2^WORK_FRAC)
	localparam logic [32:0]        INV_LN2_Q32 = 33'h171547653;
	localparam logic signed [31:0] LN2_W       = 32'sd744261118;

	// polynomial datapath word
	typedef logic signed [33:0] poly_t;
	typedef logic signed [65:0] prod_t;

	// round(2^WORK_FRAC / n!) for n = 0..7
	localparam poly_t COEF [0:7] = '{
		34'sd1073741824, 34'sd1073741824, 34'sd536870912, 34'sd178956971,
		34'sd44739243, 34'sd8947849, 34'sd1491308, 34'sd213044
	};

	localparam int HORNER_STEPS = 7;
	localparam int DEN_W        = 51;
	localparam int QUO_W        = 17;

	// side information that travels with each transaction
	typedef struct packed {
		logic last;
		logic sat_zero;
		logic sat_one;
	} meta_t;

endpackage

`default_nettype wire

// ===== design/sigmoid_activation_unit.sv =====
`default_nettype none

// channel | signals                               | direction
// --------+---------------------------------------+----------
// input   | in_valid, in_ready, x_value, last_in   | in
// output  | out_valid, out_ready, sigmoid_value,   | out
//         | last_out                               |
//
// one transaction per clock while no result waits in the skid register
// the depth is set by seven Horner steps (multiply then round-add) and a
// 17-stage restoring divider, one quotient bit per stage
// arst_n clears all valid bits; payload registers are not reset
// a stalled output parks one result in a skid register; the pipeline then
// holds and in_ready drops until the output drains
module sigmoid_activation_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [23:0] x_value,
	input  wire logic        last_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [16:0]      sigmoid_value,
	output logic             last_out
);

	localparam int HS  = 3;                                // first Horner stage
	localparam int ES  = HS + 2 * sau_pkg::HORNER_STEPS;  // scaling stage
	localparam int DS  = ES + 1;                          // first divider stage
	localparam int NST = DS + sau_pkg::QUO_W;

	logic                  en;
	logic                  vld_s [NST];
	sau_pkg::meta_t        meta_s [NST];
	logic                  skid_full_q;
	logic [16:0]           skid_val_q;
	logic                  skid_last_q;
	logic [16:0]           res_val;

	assign en       = !skid_full_q;
	assign in_ready = en;

	// valid chain; side information moves in each stage's own register block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < NST; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// stage 1: negate, multiply by 1/ln2, align to work format
	logic signed [24:0] t_neg;
	logic signed [58:0] kprod_s1;
	logic signed [39:0] tw_s1;
	assign t_neg = -$signed({x_value[23], x_value});

	always_ff @(posedge clk) begin
		if (en) begin
			kprod_s1  <= t_neg * $signed({1'b0, sau_pkg::INV_LN2_Q32});
			tw_s1     <= {{1{t_neg[24]}}, t_neg, 14'b0};
			meta_s[0] <= '{last: last_in, sat_zero: 1'b0, sat_one: 1'b0};
		end
	end

	// stage 2: round to k, saturation decision, k * ln2
	logic signed [58:0] ksum;
	logic signed [10:0] k_full;
	logic signed [37:0] kl_s2;
	logic signed [39:0] tw_s2;
	logic signed [5:0]  k_s2;
	assign ksum   = kprod_s1 + (59'sd1 <<< (sau_pkg::IN_FRAC + 31));
	assign k_full = ksum[58:48];

	always_ff @(posedge clk) begin
		if (en) begin
			kl_s2     <= $signed(k_full[5:0]) * sau_pkg::LN2_W;
			k_s2      <= k_full[5:0];
			tw_s2     <= tw_s1;
			meta_s[1] <= '{last: meta_s[0].last,
				sat_zero: (k_full > 11'(sau_pkg::K_LIMIT)),
				sat_one:  (k_full < -11'(sau_pkg::K_LIMIT))};
		end
	end

	// stage 3: reduced argument r
	logic signed [39:0] rdiff;
	logic signed [31:0] r_s3;
	logic signed [5:0]  k_s3;
	assign rdiff = tw_s2 - 40'(kl_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3      <= rdiff[31:0];
			k_s3      <= k_s2;
			meta_s[2] <= meta_s[1];
		end
	end

	// product rounded half away from zero to the work format
	function automatic sau_pkg::poly_t rnd_work(sau_pkg::prod_t v);
		logic [65:0] mag;
		logic [65:0] sh;
		mag = v[65] ? 66'(-v) : 66'(v);
		sh  = (mag + (66'd1 << (sau_pkg::WORK_FRAC - 1))) >> sau_pkg::WORK_FRAC;
		return v[65] ? -$signed(sh[33:0]) : $signed(sh[33:0]);
	endfunction

	// Horner steps: multiply stage then coefficient add stage
	sau_pkg::prod_t     hprod_s [sau_pkg::HORNER_STEPS];
	sau_pkg::poly_t     hp_s    [sau_pkg::HORNER_STEPS];
	logic signed [31:0] hrm_s   [sau_pkg::HORNER_STEPS];
	logic signed [31:0] hra_s   [sau_pkg::HORNER_STEPS];
	logic signed [5:0]  hkm_s   [sau_pkg::HORNER_STEPS];
	logic signed [5:0]  hka_s   [sau_pkg::HORNER_STEPS];

	for (genvar j = 0; j < sau_pkg::HORNER_STEPS; j++) begin : g_horner
		sau_pkg::poly_t     p_in;
		logic signed [31:0] r_in;
		logic signed [5:0]  k_in;
		if (j == 0) begin : g_first
			assign p_in = sau_pkg::COEF[7];
			assign r_in = r_s3;
			assign k_in = k_s3;
		end else begin : g_next
			assign p_in = hp_s[j-1];
			assign r_in = hra_s[j-1];
			assign k_in = hka_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hprod_s[j]         <= p_in * r_in;
				hrm_s[j]           <= r_in;
				hkm_s[j]           <= k_in;
				meta_s[HS + 2*j]   <= meta_s[HS + 2*j - 1];
				hp_s[j]            <= sau_pkg::COEF[6-j] + rnd_work(hprod_s[j]);
				hra_s[j]           <= hrm_s[j];
				hka_s[j]           <= hkm_s[j];
				meta_s[HS + 2*j+1] <= meta_s[HS + 2*j];
			end
		end
	end

	// scaling by 2^k, denominator and rounded numerator
	localparam int LST = sau_pkg::HORNER_STEPS - 1;
	logic [32:0]                    pc;
	logic signed [5:0]              kf;
	logic [4:0]                     ksh;
	logic [sau_pkg::DEN_W-1:0]      e_val;
	logic [sau_pkg::DEN_W-1:0]      den_c;
	logic [sau_pkg::DEN_W-1:0]      den_e;
	logic [sau_pkg::DEN_W-1:0]      num_e;

	assign pc    = hp_s[LST][33] ? 33'd0 : hp_s[LST][32:0];
	assign kf    = hka_s[LST];
	assign ksh   = kf[5] ? 5'(-kf) : kf[4:0];
	assign den_c = (51'd1 << sau_pkg::WORK_FRAC) + e_val;

	always_comb begin
		if (!kf[5]) begin
			e_val = 51'(pc) << ksh;
		end else begin
			e_val = (51'(pc) + (51'd1 << (ksh - 5'd1))) >> ksh;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_e      <= den_c;
			num_e      <= (51'd1 << (sau_pkg::OUT_FRAC + sau_pkg::WORK_FRAC)) + (den_c >> 1);
			meta_s[ES] <= meta_s[ES-1];
		end
	end

	// restoring divider, one quotient bit per stage
	logic [sau_pkg::DEN_W-1:0] dr_s [sau_pkg::QUO_W];
	logic [sau_pkg::DEN_W-1:0] dd_s [sau_pkg::QUO_W];
	logic [sau_pkg::DEN_W-1:0] dn_s [sau_pkg::QUO_W];
	logic [sau_pkg::QUO_W-1:0] dq_s [sau_pkg::QUO_W];

	for (genvar i = 0; i < sau_pkg::QUO_W; i++) begin : g_div
		logic [sau_pkg::DEN_W-1:0] rem_in;
		logic [sau_pkg::DEN_W-1:0] den_in;
		logic [sau_pkg::DEN_W-1:0] num_in;
		logic [sau_pkg::QUO_W-1:0] quo_in;
		logic [sau_pkg::DEN_W:0]   trial;
		logic                      take;
		if (i == 0) begin : g_first
			assign rem_in = num_e >> sau_pkg::QUO_W;
			assign den_in = den_e;
			assign num_in = num_e;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = dr_s[i-1];
			assign den_in = dd_s[i-1];
			assign num_in = dn_s[i-1];
			assign quo_in = dq_s[i-1];
		end
		assign trial = {rem_in, num_in[sau_pkg::QUO_W-1-i]};
		assign take  = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				dr_s[i]        <= take ? 51'(trial - {1'b0, den_in}) : trial[50:0];
				dd_s[i]        <= den_in;
				dn_s[i]        <= num_in;
				dq_s[i]        <= {quo_in[sau_pkg::QUO_W-2:0], take};
				meta_s[DS + i] <= meta_s[DS + i - 1];
			end
		end
	end

	// final clamp and saturation
	localparam logic [16:0] ONE_OUT = 17'd1 << sau_pkg::OUT_FRAC;
	sau_pkg::meta_t lmeta;
	assign lmeta = meta_s[NST-1];

	always_comb begin
		if (lmeta.sat_zero) begin
			res_val = '0;
		end else if (lmeta.sat_one || dq_s[sau_pkg::QUO_W-1] > ONE_OUT) begin
			res_val = ONE_OUT;
		end else begin
			res_val = dq_s[sau_pkg::QUO_W-1];
		end
	end

	// output register with one-entry skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (out_ready || !out_valid) begin
			if (skid_full_q) begin
				out_valid   <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid <= vld_s[NST-1];
			end
		end else if (vld_s[NST-1]) begin
			skid_full_q <= 1'b1;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_ready || !out_valid) begin
			if (skid_full_q) begin
				sigmoid_value <= skid_val_q;
				last_out      <= skid_last_q;
			end else begin
				sigmoid_value <= res_val;
				last_out      <= lmeta.last;
			end
		end else if (en) begin
			skid_val_q  <= res_val;
			skid_last_q <= lmeta.last;
		end
	end

	// checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid)
		else $error("skid holds a result while output is empty");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sigmoid_value <= ONE_OUT)
		else $error("result above 1.0");

	a_sat_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[1] |-> !(meta_s[1].sat_zero && meta_s[1].sat_one))
		else $error("both saturation flags set");

	a_skid_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |=> (!$past(out_ready) |-> skid_full_q))
		else $error("skid dropped without output handshake");

endmodule

`default_nettype wire

// ===== test/sigmoid_scoreboard.sv =====
module sigmoid_scoreboard (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [23:0] x_value,
	input  wire logic        last_in,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [16:0] sigmoid_value,
	input  wire logic        last_out,
	output int               fail_count,
	output int               pending,
	output int               checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [16:0] value;
		logic        last;
	} sig_result_t;

	localparam longint K_SAT      = 18;
	localparam longint INV_LN2    = 64'h171547653;
	localparam longint LN2_Q30    = 744261118;
	localparam longint ONE_Q30    = 64'd1 << 30;
	localparam int     REPORT_MAX = 10;

	sig_result_t awaiting_q[$];

	// a*b / 2^30, rounded half away from zero
	function automatic longint q30_mul(longint a, longint b);
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [127:0] prod;
		logic [63:0]  mag;
		ua   = (a < 0) ? -a : a;
		ub   = (b < 0) ? -b : b;
		prod = ua * ub;
		prod = prod + (128'd1 << 29);
		mag  = prod[93:30];
		return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
	endfunction

	// sigmoid of a Q7.16 sample as Q1.16 with saturation of the far tails
	function automatic logic [16:0] sigmoid_of(logic signed [23:0] x);
		longint      t;
		longint      k;
		longint      r;
		longint      p;
		longint      fact;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] quo;
		t = -longint'(x);
		k = (t * INV_LN2 + (longint'(1) << 47)) >>> 48;
		if (k > K_SAT)
			return 17'd0;
		if (k < -K_SAT)
			return 17'd65536;
		r = (t <<< 14) - k * LN2_Q30;
		// horner over taylor terms, 1/7! down to 1/0!
		fact = 5040;
		p    = (ONE_Q30 + fact / 2) / fact;
		for (int n = 6; n >= 0; n--) begin
			fact = (n == 0) ? 1 : fact / (n + 1);
			p    = (ONE_Q30 + fact / 2) / fact + q30_mul(p, r);
		end
		if (p < 0)
			p = 0;
		if (k >= 0)
			e = 64'(p) << k;
		else
			e = (64'(p) + (64'd1 << (-k - 1))) >> (-k);
		den = 64'(ONE_Q30) + e;
		quo = ((64'd1 << 46) + den / 2) / den;
		if (quo > 64'd65536)
			quo = 64'd65536;
		return quo[16:0];
	endfunction

	assign pending = awaiting_q.size();

	// predict on input transactions, compare on output transactions
	always @(posedge clk) begin
		sig_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				awaiting_q.push_back('{value: sigmoid_of(x_value), last: last_in});
			if (out_valid && out_ready) begin
				checked <= checked + 1;
				if (awaiting_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < REPORT_MAX)
						$display("unexpected transaction: value %0d last %0b",
							sigmoid_value, last_out);
				end else begin
					want = awaiting_q.pop_front();
					if (want.value !== sigmoid_value || want.last !== last_out) begin
						fail_count <= fail_count + 1;
						if (fail_count < REPORT_MAX)
							$display("mismatch: value exp %0d got %0d, last exp %0b got %0b",
								want.value, sigmoid_value, want.last, last_out);
					end
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		checked    = 0;
	end
endmodule

// ===== test/tb_sigmoid_activation_unit.sv =====
module tb_sigmoid_activation_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1250;
	localparam int DRAIN_CYCLES = 60;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [23:0] x_value;
	logic        last_in;
	logic        out_valid;
	logic        out_ready;
	logic [16:0] sigmoid_value;
	logic        last_out;
	int          fail_count;
	int          pending;
	int          checked;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          cycles;

	sigmoid_activation_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .x_value(x_value), .last_in(last_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.sigmoid_value(sigmoid_value), .last_out(last_out)
	);

	sigmoid_scoreboard u_scoreboard (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .x_value(x_value), .last_in(last_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.sigmoid_value(sigmoid_value), .last_out(last_out),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** sigmoid_activation_unit: FAILED **");
			$finish;
		end
	end

	// one input transaction, with random idle gaps before it
	task automatic send_sample(logic [23:0] x, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		x_value  <= x;
		last_in  <= last;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// mostly the interesting range around zero, sometimes anywhere
	function automatic logic [23:0] random_sample();
		int sel;
		sel = $urandom_range(9);
		if (sel < 6)
			return 24'($signed($urandom_range(2 * 15 * 65536)) - 15 * 65536);
		else if (sel < 8)
			return 24'($signed($urandom_range(2 * 65536)) - 65536);
		return 24'($urandom);
	endfunction

	initial begin
		logic [23:0] edge_vals [$];
		cycles         = 0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		x_value        = '0;
		last_in        = 1'b0;
		out_ready      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// extremes, zero, values just past the saturation boundaries and the k = 0 rounding edge
		edge_vals = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'h000001, 24'hFFFFFF,
			24'd840385, 24'd840386, 24'd840387, -24'd840385, -24'd840386,
			-24'd840387, 24'd22712, 24'd22713, 24'd22714, -24'd22712,
			-24'd22713, -24'd22714, 24'd65536, -24'd65536, 24'h555555, 24'hAAAAAA};
		foreach (edge_vals[i])
			send_sample(edge_vals[i], i[0]);

		// random part across the idling phases
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case (i * 4 / RANDOM_ITEMS)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			send_sample(random_sample(), 1'($urandom_range(1)));
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d results: extremes, saturation and rounding edges,", checked);
		$display("random samples under free flow, sender gaps and receiver stalls");
		if (fail_count == 0)
			$display("** sigmoid_activation_unit: PASSED **");
		else
			$display("** sigmoid_activation_unit: FAILED **");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/sau_pkg.sv
design/sigmoid_activation_unit.sv
test/sigmoid_scoreboard.sv
test/tb_sigmoid_activation_unit.sv
